[hdl/wave_gradient_pixel_generator_macros.svh]
// Assertion macros shared by the wave gradient pixel generator.
`ifndef WAVE_GRADIENT_PIXEL_GENERATOR_MACROS_SVH
`define WAVE_GRADIENT_PIXEL_GENERATOR_MACROS_SVH
// The condition implies the expression in the same cycle.
`define WGPG_ASSERT_SAME(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("wgpg: same-cycle check failed");
// The condition implies the expression in the next cycle.
`define WGPG_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("wgpg: next-cycle check failed");
`endif

[hdl/wgpg_pkg.sv]
// Package with the types, constants and sine table of the wave gradient pixel generator.
package wgpg_pkg;

    localparam int MAX_SCREEN_SIDE = 4096;
    localparam int QUEUE_DEPTH     = 4;
    localparam int SIDE_REG_W      = 13;

    localparam logic [1:0] MODE_BG   = 2'd0;
    localparam logic [1:0] MODE_GRAD = 2'd1;
    localparam logic [1:0] MODE_WAVE = 2'd2;

    localparam logic [2:0] REG_MODE         = 3'd0;
    localparam logic [2:0] REG_COLOR_TOP    = 3'd1;
    localparam logic [2:0] REG_COLOR_BOTTOM = 3'd2;
    localparam logic [2:0] REG_PHASE_STEP   = 3'd3;
    localparam logic [2:0] REG_WIDTH        = 3'd4;
    localparam logic [2:0] REG_HEIGHT       = 3'd5;

    localparam logic [31:0] BG_COLOR      = 32'hFF0A0E1A;
    localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;
    localparam logic [9:0]  DEG_FULL      = 10'd360;
    localparam logic [9:0]  DEG_HALF      = 10'd180;
    localparam logic [9:0]  DEG_QUARTER   = 10'd90;
    localparam logic [9:0]  DEG_3QUARTER  = 10'd270;
    localparam logic [11:0] DIV20_RECIP   = 12'd3277;
    localparam logic [8:0]  BLEND_ONE     = 9'd256;
    localparam logic [7:0]  RATIO_MAX     = 8'd255;

    typedef struct packed {
        logic [1:0]  mode;
        logic [23:0] color_top;
        logic [23:0] color_bottom;
        logic [8:0]  phase_step;
        logic [12:0] screen_width;
        logic [12:0] screen_height;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        mode:          MODE_WAVE,
        color_top:     24'h0A0E1A,
        color_bottom:  24'h0066FF,
        phase_step:    9'd1,
        screen_width:  13'd1024,
        screen_height: 13'd768
    };

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [8:0]  phase;
        logic [1:0]  mode;
    } item_t;

    // Sine over the first quadrant in thousandths, one entry per degree.
    function automatic logic [9:0] quarter_sine(input logic [6:0] idx);
        logic [9:0] s;
        case (idx)
            7'd0: s = 10'd0;     7'd1: s = 10'd17;    7'd2: s = 10'd35;
            7'd3: s = 10'd52;    7'd4: s = 10'd70;    7'd5: s = 10'd87;
            7'd6: s = 10'd105;   7'd7: s = 10'd122;   7'd8: s = 10'd139;
            7'd9: s = 10'd156;   7'd10: s = 10'd174;  7'd11: s = 10'd191;
            7'd12: s = 10'd208;  7'd13: s = 10'd225;  7'd14: s = 10'd242;
            7'd15: s = 10'd259;  7'd16: s = 10'd276;  7'd17: s = 10'd292;
            7'd18: s = 10'd309;  7'd19: s = 10'd326;  7'd20: s = 10'd342;
            7'd21: s = 10'd358;  7'd22: s = 10'd375;  7'd23: s = 10'd391;
            7'd24: s = 10'd407;  7'd25: s = 10'd423;  7'd26: s = 10'd438;
            7'd27: s = 10'd454;  7'd28: s = 10'd469;  7'd29: s = 10'd485;
            7'd30: s = 10'd500;  7'd31: s = 10'd515;  7'd32: s = 10'd530;
            7'd33: s = 10'd545;  7'd34: s = 10'd559;  7'd35: s = 10'd574;
            7'd36: s = 10'd588;  7'd37: s = 10'd602;  7'd38: s = 10'd616;
            7'd39: s = 10'd629;  7'd40: s = 10'd643;  7'd41: s = 10'd656;
            7'd42: s = 10'd669;  7'd43: s = 10'd682;  7'd44: s = 10'd695;
            7'd45: s = 10'd707;  7'd46: s = 10'd719;  7'd47: s = 10'd731;
            7'd48: s = 10'd743;  7'd49: s = 10'd755;  7'd50: s = 10'd766;
            7'd51: s = 10'd777;  7'd52: s = 10'd788;  7'd53: s = 10'd799;
            7'd54: s = 10'd809;  7'd55: s = 10'd819;  7'd56: s = 10'd829;
            7'd57: s = 10'd839;  7'd58: s = 10'd848;  7'd59: s = 10'd857;
            7'd60: s = 10'd866;  7'd61: s = 10'd875;  7'd62: s = 10'd883;
            7'd63: s = 10'd891;  7'd64: s = 10'd899;  7'd65: s = 10'd906;
            7'd66: s = 10'd914;  7'd67: s = 10'd921;  7'd68: s = 10'd927;
            7'd69: s = 10'd934;  7'd70: s = 10'd940;  7'd71: s = 10'd946;
            7'd72: s = 10'd951;  7'd73: s = 10'd956;  7'd74: s = 10'd961;
            7'd75: s = 10'd966;  7'd76: s = 10'd970;  7'd77: s = 10'd974;
            7'd78: s = 10'd978;  7'd79: s = 10'd982;  7'd80: s = 10'd985;
            7'd81: s = 10'd988;  7'd82: s = 10'd990;  7'd83: s = 10'd993;
            7'd84: s = 10'd995;  7'd85: s = 10'd996;  7'd86: s = 10'd998;
            7'd87: s = 10'd999;  7'd88: s = 10'd999;  7'd89: s = 10'd1000;
            7'd90: s = 10'd1000;
            default: s = 10'd0;
        endcase
        return s;
    endfunction

endpackage

[hdl/wgpg_if.sv]
// Valid/ready channel interfaces for pixels, colors and configuration writes.
interface wgpg_pixel_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        frame_start;
    modport source (output valid, output pixel_x, output pixel_y, output frame_start,
                    input ready);
    modport sink (input valid, input pixel_x, input pixel_y, input frame_start,
                  output ready);
endinterface

interface wgpg_color_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_color;
    modport source (output valid, output pixel_color, input ready);
    modport sink (input valid, input pixel_color, output ready);
endinterface

interface wgpg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/wgpg_front.sv]
// Front end: configuration registers, wave phase and intake of pixel items.
module wgpg_front
(
    input  logic              clk,
    input  logic              rst_n,
    wgpg_pixel_if.sink        pixel,
    wgpg_cfg_if.sink          cfg,
    input  logic              q_full,
    output logic              q_push,
    output wgpg_pkg::item_t   q_item,
    output wgpg_pkg::cfg_t    cfg_regs,
    output logic [8:0]        wave_phase
);

    wgpg_pkg::cfg_t cfg_reg;
    wgpg_pkg::cfg_t cfg_next;
    logic [8:0]     phase_reg;
    logic [8:0]     phase_next;
    logic [9:0]     phase_sum;
    logic [8:0]     phase_adv;
    logic           accept;

    assign cfg.ready  = 1'b1;
    assign pixel.ready = !q_full;
    assign accept     = pixel.valid && pixel.ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                wgpg_pkg::REG_MODE:         cfg_next.mode = cfg.data[1:0];
                wgpg_pkg::REG_COLOR_TOP:    cfg_next.color_top = cfg.data;
                wgpg_pkg::REG_COLOR_BOTTOM: cfg_next.color_bottom = cfg.data;
                wgpg_pkg::REG_PHASE_STEP:   cfg_next.phase_step = cfg.data[8:0];
                wgpg_pkg::REG_WIDTH:        cfg_next.screen_width = cfg.data[12:0];
                wgpg_pkg::REG_HEIGHT:       cfg_next.screen_height = cfg.data[12:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // The step may exceed a full turn, so the sum can need two wraps.
    always_comb
    begin
        phase_sum = {1'b0, phase_reg} + {1'b0, cfg_reg.phase_step};
        if (phase_sum >= (wgpg_pkg::DEG_FULL << 1))
            phase_adv = 9'(phase_sum - (wgpg_pkg::DEG_FULL << 1));
        else if (phase_sum >= wgpg_pkg::DEG_FULL)
            phase_adv = 9'(phase_sum - wgpg_pkg::DEG_FULL);
        else
            phase_adv = phase_sum[8:0];

        if (accept && pixel.frame_start && (cfg_reg.mode == wgpg_pkg::MODE_WAVE))
            phase_next = phase_adv;
        else
            phase_next = phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= wgpg_pkg::CFG_RESET;
            phase_reg <= 9'd0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            phase_reg <= phase_next;
        end
    end

    assign q_push       = accept;
    assign q_item.x     = pixel.pixel_x;
    assign q_item.y     = pixel.pixel_y;
    assign q_item.phase = phase_next;
    assign q_item.mode  = cfg_reg.mode;
    assign cfg_regs     = cfg_reg;
    assign wave_phase   = phase_reg;

endmodule

[hdl/wgpg_fifo.sv]
// Short queue of classified items between the front and back ends.
module wgpg_fifo
#(
    parameter int DEPTH = wgpg_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  wgpg_pkg::item_t push_item,
    input  logic            pop,
    output wgpg_pkg::item_t head_item,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wgpg_pkg::item_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[hdl/wgpg_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
module wgpg_div
#(
    parameter int Q_W = 8,
    parameter int D_W = 13,
    parameter int P_W = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [D_W-1:0] in_rem,
    input  logic [Q_W-1:0] in_num,
    input  logic [P_W-1:0] in_side,
    input  logic [D_W-1:0] den,
    output logic           out_valid,
    output logic [Q_W-1:0] out_quo,
    output logic [D_W-1:0] out_rem,
    output logic [P_W-1:0] out_side
);

    // The incoming remainder must already be below the divisor.
    logic           v_reg    [Q_W];
    logic [D_W-1:0] rem_reg  [Q_W];
    logic [Q_W-1:0] num_reg  [Q_W];
    logic [Q_W-1:0] quo_reg  [Q_W];
    logic [P_W-1:0] side_reg [Q_W];

    logic           v_prev    [Q_W];
    logic [D_W-1:0] rem_prev  [Q_W];
    logic [Q_W-1:0] num_prev  [Q_W];
    logic [Q_W-1:0] quo_prev  [Q_W];
    logic [P_W-1:0] side_prev [Q_W];

    logic [D_W-1:0] rem_next  [Q_W];
    logic [Q_W-1:0] num_next  [Q_W];
    logic [Q_W-1:0] quo_next  [Q_W];

    always_comb
    begin
        logic [D_W:0] trial;
        logic         ge;
        for (int s = 0; s < Q_W; s++)
        begin
            if (s == 0)
            begin
                v_prev[s]    = in_valid;
                rem_prev[s]  = in_rem;
                num_prev[s]  = in_num;
                quo_prev[s]  = '0;
                side_prev[s] = in_side;
            end
            else
            begin
                v_prev[s]    = v_reg[s-1];
                rem_prev[s]  = rem_reg[s-1];
                num_prev[s]  = num_reg[s-1];
                quo_prev[s]  = quo_reg[s-1];
                side_prev[s] = side_reg[s-1];
            end
            trial = {rem_prev[s], num_prev[s][Q_W-1]};
            ge    = (trial >= {1'b0, den});
            rem_next[s] = ge ? D_W'(trial - {1'b0, den}) : trial[D_W-1:0];
            num_next[s] = {num_prev[s][Q_W-2:0], 1'b0};
            quo_next[s] = {quo_prev[s][Q_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < Q_W; s++)
                v_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            for (int s = 0; s < Q_W; s++)
                v_reg[s] <= v_prev[s];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < Q_W; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                num_reg[s]  <= num_next[s];
                quo_reg[s]  <= quo_next[s];
                side_reg[s] <= side_prev[s];
            end
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign out_quo   = quo_reg[Q_W-1];
    assign out_rem   = rem_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

[hdl/wgpg_back.sv]
// Back end: wave angle, sine offset, blend ratio and color blend pipeline.
module wgpg_back
#(
    parameter int MAX_SCREEN_SIDE = wgpg_pkg::MAX_SCREEN_SIDE
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  wgpg_pkg::cfg_t  cfg_regs,
    input  logic            q_empty,
    input  wgpg_pkg::item_t q_item,
    output logic            q_pop,
    wgpg_color_if.source    color
);

    localparam int SIDE_FULL_W = $clog2(MAX_SCREEN_SIDE + 1);
    localparam int SIDE_W = (SIDE_FULL_W < wgpg_pkg::SIDE_REG_W) ? SIDE_FULL_W
                                                                  : wgpg_pkg::SIDE_REG_W;
    localparam int N_W    = SIDE_W + 9;
    localparam int SIDE_A = 23;
    localparam int SIDE_C = 4;

    logic              en;
    logic [SIDE_W-1:0] width_c;
    logic [SIDE_W-1:0] height_c;

    assign en    = !color.valid || color.ready;
    assign q_pop = en && !q_empty;

    // Divisors are taken as at least one and at most the largest side.
    always_comb
    begin
        if (cfg_regs.screen_width == '0)
            width_c = SIDE_W'(1);
        else if (32'(cfg_regs.screen_width) > 32'(MAX_SCREEN_SIDE))
            width_c = SIDE_W'(MAX_SCREEN_SIDE);
        else
            width_c = cfg_regs.screen_width[SIDE_W-1:0];
        if (cfg_regs.screen_height == '0)
            height_c = SIDE_W'(1);
        else if (32'(cfg_regs.screen_height) > 32'(MAX_SCREEN_SIDE))
            height_c = SIDE_W'(MAX_SCREEN_SIDE);
        else
            height_c = cfg_regs.screen_height[SIDE_W-1:0];
    end

    // Column modulo width: the angle only needs the fraction x/width of a turn.
    logic              a_v;
    logic [SIDE_W-1:0] a_rem;
    logic [SIDE_A-1:0] a_side;

    wgpg_div #(.Q_W(12), .D_W(SIDE_W), .P_W(SIDE_A)) u_div_col
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_pop),
        .in_rem    ('0),
        .in_num    (q_item.x),
        .in_side   ({q_item.y, q_item.phase, q_item.mode}),
        .den       (width_c),
        .out_valid (a_v),
        .out_quo   (),
        .out_rem   (a_rem),
        .out_side  (a_side)
    );

    logic              p1_v_reg;
    logic [N_W-1:0]    n_reg;
    logic [SIDE_A-1:0] p1_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg       <= N_W'(a_rem) * N_W'(wgpg_pkg::DEG_FULL);
            p1_side_reg <= a_side;
        end
    end

    // Remainder times 360 over width is below 360, so nine quotient bits suffice.
    logic              b_v;
    logic [8:0]        b_quo;
    logic [SIDE_A-1:0] b_side;

    wgpg_div #(.Q_W(9), .D_W(SIDE_W), .P_W(SIDE_A)) u_div_ang
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p1_v_reg),
        .in_rem    (n_reg[N_W-1:9]),
        .in_num    (n_reg[8:0]),
        .in_side   (p1_side_reg),
        .den       (width_c),
        .out_valid (b_v),
        .out_quo   (b_quo),
        .out_rem   (),
        .out_side  (b_side)
    );

    logic       p2_v_reg;
    logic [8:0] ang_reg;
    logic [11:0] p2_y_reg;
    logic [1:0] p2_mode_reg;
    logic [9:0] ang_sum;

    assign ang_sum = {1'b0, b_quo} + {1'b0, b_side[10:2]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg     <= (ang_sum >= wgpg_pkg::DEG_FULL) ? 9'(ang_sum - wgpg_pkg::DEG_FULL)
                                                           : ang_sum[8:0];
            p2_y_reg    <= b_side[22:11];
            p2_mode_reg <= b_side[1:0];
        end
    end

    // Fold the angle onto the quarter-wave table.
    logic        p3_v_reg;
    logic [9:0]  mag_reg;
    logic        neg_reg;
    logic [11:0] p3_y_reg;
    logic [1:0]  p3_mode_reg;
    logic [9:0]  ang_w;
    logic [9:0]  fold_idx;
    logic        fold_neg;

    always_comb
    begin
        ang_w = {1'b0, ang_reg};
        if (ang_w <= wgpg_pkg::DEG_QUARTER)
        begin
            fold_idx = ang_w;
            fold_neg = 1'b0;
        end
        else if (ang_w <= wgpg_pkg::DEG_HALF)
        begin
            fold_idx = wgpg_pkg::DEG_HALF - ang_w;
            fold_neg = 1'b0;
        end
        else if (ang_w <= wgpg_pkg::DEG_3QUARTER)
        begin
            fold_idx = ang_w - wgpg_pkg::DEG_HALF;
            fold_neg = 1'b1;
        end
        else
        begin
            fold_idx = wgpg_pkg::DEG_FULL - ang_w;
            fold_neg = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg     <= wgpg_pkg::quarter_sine(fold_idx[6:0]);
            neg_reg     <= fold_neg;
            p3_y_reg    <= p2_y_reg;
            p3_mode_reg <= p2_mode_reg;
        end
    end

    // Magnitude over 20 by reciprocal; exact for magnitudes up to 1000.
    logic        p4_v_reg;
    logic [13:0] adj_reg;
    logic [11:0] p4_y_reg;
    logic [1:0]  p4_mode_reg;
    logic [21:0] recip_prod;
    logic [5:0]  wave_mag;
    logic [13:0] y_ext;

    assign recip_prod = 22'(mag_reg) * 22'(wgpg_pkg::DIV20_RECIP);
    assign wave_mag   = recip_prod[21:16];
    assign y_ext      = {2'b00, p3_y_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adj_reg     <= neg_reg ? (y_ext - {8'd0, wave_mag}) : (y_ext + {8'd0, wave_mag});
            p4_y_reg    <= p3_y_reg;
            p4_mode_reg <= p3_mode_reg;
        end
    end

    // Pick the row, flag a negative row and saturation, then divide.
    logic              p5_v_reg;
    logic [SIDE_W-1:0] rem5_reg;
    logic              sat5_reg;
    logic              zero5_reg;
    logic [1:0]        p5_mode_reg;
    logic [12:0]       row_val;
    logic              row_neg;
    logic              row_sat;

    always_comb
    begin
        if (p4_mode_reg == wgpg_pkg::MODE_WAVE)
        begin
            row_val = adj_reg[12:0];
            row_neg = adj_reg[13];
        end
        else
        begin
            row_val = {1'b0, p4_y_reg};
            row_neg = 1'b0;
        end
        row_sat = (32'(row_val) >= 32'(height_c));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem5_reg    <= (row_neg || row_sat) ? '0 : row_val[SIDE_W-1:0];
            sat5_reg    <= row_sat && !row_neg;
            zero5_reg   <= row_neg;
            p5_mode_reg <= p4_mode_reg;
        end
    end

    logic              c_v;
    logic [7:0]        c_quo;
    logic [SIDE_C-1:0] c_side;

    wgpg_div #(.Q_W(8), .D_W(SIDE_W), .P_W(SIDE_C)) u_div_ratio
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p5_v_reg),
        .in_rem    (rem5_reg),
        .in_num    ('0),
        .in_side   ({sat5_reg, zero5_reg, p5_mode_reg}),
        .den       (height_c),
        .out_valid (c_v),
        .out_quo   (c_quo),
        .out_rem   (),
        .out_side  (c_side)
    );

    // Blend the channels or use the background color; register the result for the output.
    logic        out_v_reg;
    logic [31:0] out_color_reg;
    logic [7:0]  ratio;
    logic [8:0]  inv;
    logic [31:0] color_next;

    always_comb
    begin
        logic [16:0] mix;
        if (c_side[2])
            ratio = 8'd0;
        else if (c_side[3])
            ratio = wgpg_pkg::RATIO_MAX;
        else
            ratio = c_quo;
        inv = wgpg_pkg::BLEND_ONE - {1'b0, ratio};
        color_next = {wgpg_pkg::ALPHA_OPAQUE, 24'd0};
        for (int ch = 0; ch < 3; ch++)
        begin
            mix = 17'(cfg_regs.color_top[ch*8 +: 8]) * 17'(inv)
                + 17'(cfg_regs.color_bottom[ch*8 +: 8]) * 17'(ratio);
            color_next[ch*8 +: 8] = mix[15:8];
        end
        if ((c_side[1:0] != wgpg_pkg::MODE_GRAD) && (c_side[1:0] != wgpg_pkg::MODE_WAVE))
            color_next = wgpg_pkg::BG_COLOR;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_color_reg <= color_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            p4_v_reg  <= 1'b0;
            p5_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_v_reg  <= a_v;
            p2_v_reg  <= b_v;
            p3_v_reg  <= p2_v_reg;
            p4_v_reg  <= p3_v_reg;
            p5_v_reg  <= p4_v_reg;
            out_v_reg <= c_v;
        end
    end

    assign color.valid       = out_v_reg;
    assign color.pixel_color = out_color_reg;

endmodule

[hdl/wave_gradient_pixel_generator.sv]
// Throughput: one item per cycle unless the output stalls.
// The back-end pipeline carries 35 items at once.
// It holds three bit-per-stage dividers (12, 9 and 8 stages).
// The four-entry queue takes items until full while a stalled output holds the pipeline.
// Reset (rst_n, asynchronous, active low) restores the register defaults, zeroes
// the wave phase and empties the queue and pipeline; no clearing pass follows.
`include "wave_gradient_pixel_generator_macros.svh"

module wave_gradient_pixel_generator
#(
    parameter int MAX_SCREEN_SIDE = wgpg_pkg::MAX_SCREEN_SIDE,
    parameter int QUEUE_DEPTH     = wgpg_pkg::QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    wgpg_pixel_if.sink   pixel,
    wgpg_color_if.source color,
    wgpg_cfg_if.sink     cfg
);

    // The front end owns the configuration and the wave phase. It stamps each
    // item with the phase that applies to it (already advanced on a frame
    // start) and the mode, so the back end needs no feedback from it.
    wgpg_pkg::item_t q_item_in;
    wgpg_pkg::item_t q_item_out;
    wgpg_pkg::cfg_t  cfg_regs;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    logic [8:0]      wave_phase;

    wgpg_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .cfg        (cfg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_item_in),
        .cfg_regs   (cfg_regs),
        .wave_phase (wave_phase)
    );

    // The queue decouples intake from the back end, which stalls as a whole
    // when the output item is not taken.
    wgpg_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item_in),
        .pop       (q_pop),
        .head_item (q_item_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    // The back end computes the wave angle from the column, the sine offset,
    // the blend ratio from the row, shifted in wave mode, and finally the blended color.
    wgpg_back #(.MAX_SCREEN_SIDE(MAX_SCREEN_SIDE)) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_regs),
        .q_empty  (q_empty),
        .q_item   (q_item_out),
        .q_pop    (q_pop),
        .color    (color)
    );

    // The phase stays a valid angle.
    `WGPG_ASSERT_SAME(a_phase_range, 1'b1, wave_phase < 9'd360)
    // Outside wave mode an accepted item never moves the phase.
    `WGPG_ASSERT_NEXT(a_phase_hold, pixel.valid && pixel.ready && cfg_regs.mode != wgpg_pkg::MODE_WAVE, $stable(wave_phase))
    // Every delivered color is opaque.
    `WGPG_ASSERT_SAME(a_alpha, color.valid, color.pixel_color[31:24] == wgpg_pkg::ALPHA_OPAQUE)

endmodule
